### design/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps
package mcr_pkg;

  localparam int COORD_W = 10;
  localparam int RAD_W   = COORD_W - 1;
  localparam int OCT_W   = COORD_W + 1;   // signed octant position, y may reach -1
  localparam int DEC_W   = COORD_W + 2;   // signed decision value
  localparam int OUT_W   = COORD_W + 2;   // signed point coordinates
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [COORD_W-1:0] CENTER_X_RST = COORD_W'(450);
  localparam logic [COORD_W-1:0] CENTER_Y_RST = COORD_W'(450);
  localparam logic [RAD_W-1:0]   RADIUS_RST   = RAD_W'(110);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_e;

  // One step worth of work handed from front to back.
  typedef struct packed {
    logic signed [OCT_W-1:0] x;
    logic signed [OCT_W-1:0] y;
    logic [COORD_W-1:0]      cx;
    logic [COORD_W-1:0]      cy;
    logic                    done;
  } step_t;

endpackage

### design/mcr_front.sv
// Front end: config registers, octant state, midpoint advance, step issue.
`timescale 1ns / 1ps
module mcr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mcr_pkg::COORD_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mcr_pkg::step_t               step_o
);
  import mcr_pkg::*;

  logic [COORD_W-1:0]      center_x_q, center_y_q;
  logic [RAD_W-1:0]        radius_q;
  logic signed [OCT_W-1:0] x_q, x_d, y_q, y_d, x0, y0;
  logic signed [DEC_W-1:0] dec_q, dec_d, d0;
  logic                    fin_q, fin_d, fin0, accept, done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      radius_q   <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_RADIUS:   radius_q   <= cfg_data_i[RAD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    // restart loads (0, r) and 1 - r, then steps as usual
    if (restart_i) begin
      x0   = '0;
      y0   = signed'({2'b00, radius_q});
      d0   = DEC_W'(1) - signed'({3'b000, radius_q});
      fin0 = 1'b0;
    end else begin
      x0   = x_q;
      y0   = y_q;
      d0   = dec_q;
      fin0 = fin_q;
    end
    x_d = x0 + OCT_W'(1);
    if (d0 < 0) begin
      y_d   = y0;
      dec_d = d0 + DEC_W'({x_d, 1'b1});
    end else begin
      y_d   = y0 - OCT_W'(1);
      dec_d = d0 + DEC_W'({(x_d - y_d), 1'b1});
    end
    done = x_d > y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      dec_q <= '0;
      fin_q <= 1'b1;
    end else if (accept) begin
      if (fin0) begin
        fin_q <= 1'b1;
      end else begin
        x_q   <= x_d;
        y_q   <= y_d;
        dec_q <= dec_d;
        fin_q <= done;
      end
    end
  end

  assign push_o       = accept & ~fin0;
  assign step_o.x     = x0;
  assign step_o.y     = y0;
  assign step_o.cx    = center_x_q;
  assign step_o.cy    = center_y_q;
  assign step_o.done  = done;

endmodule

### design/mcr_fifo.sv
// Two-entry step queue between front and back.
`timescale 1ns / 1ps
module mcr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcr_pkg::step_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mcr_pkg::step_t data_o
);
  import mcr_pkg::*;

  step_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

### design/mcr_back.sv
// Back end: walks the eight mirrored points of each queued step.
`timescale 1ns / 1ps
module mcr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  mcr_pkg::step_t                    step_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mcr_pkg::OUT_W-1:0]  point_x_o,
  output logic signed [mcr_pkg::OUT_W-1:0]  point_y_o,
  output logic                              last_of_step_o,
  output logic                              circle_done_o
);
  import mcr_pkg::*;

  logic [2:0]              pt_q;
  logic                    emit, vld_q;
  logic signed [OCT_W-1:0] a, b;
  logic signed [OUT_W-1:0] cx, cy, ae, be, px_d, py_d;

  assign emit  = q_valid_i & (~vld_q | ~out_stall_i);
  assign pop_o = emit & (pt_q == 3'd7);

  // bit 2 swaps x/y, bit 1 negates the y offset, bit 0 negates the x offset
  always_comb begin
    a    = pt_q[2] ? step_i.y : step_i.x;
    b    = pt_q[2] ? step_i.x : step_i.y;
    cx   = signed'({2'b00, step_i.cx});
    cy   = signed'({2'b00, step_i.cy});
    ae   = OUT_W'(a);
    be   = OUT_W'(b);
    px_d = pt_q[0] ? cx - ae : cx + ae;
    py_d = pt_q[1] ? cy - be : cy + be;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pt_q  <= '0;
    end else begin
      if (emit) begin
        vld_q <= 1'b1;
        pt_q  <= pt_q + 3'd1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      point_x_o      <= px_d;
      point_y_o      <= py_d;
      last_of_step_o <= pt_q == 3'd7;
      circle_done_o  <= step_i.done;
    end
  end

  assign out_valid_o = vld_q;

endmodule

### design/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer.
//
//   port group   dir  handshake               payload
//   cfg          in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in           in   in_valid_i/in_stall_o   restart_i
//   out          out  out_valid_o/out_stall_i point_x_o, point_y_o,
//                                             last_of_step_o, circle_done_o
//
// A drawing step yields eight points, one per cycle from the back end unless
// the output stalls; the back end's point counter sets the rate.
// Steps without an active circle are absorbed with no output.
// The front accepts a step while the two-entry queue has room.
// Reset restores the config defaults and leaves no circle active.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcr_pkg::COORD_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mcr_pkg::OUT_W-1:0]    point_x_o,
  output logic signed [mcr_pkg::OUT_W-1:0]    point_y_o,
  output logic                                last_of_step_o,
  output logic                                circle_done_o
);
  import mcr_pkg::*;

  step_t push_step, head_step;
  logic  push, pop, q_full, q_valid;

  mcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .step_o      (push_step)
  );

  mcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_step),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_step)
  );

  mcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .step_i         (head_step),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule

### tb/sv/midpoint_circle_rasterizer_unit_tb.sv
// Self-checking testbench for the midpoint circle rasterizer unit.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_unit_tb;
  import mcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 90;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [COORD_W-1:0]        cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      restart_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b1;
  logic signed [OUT_W-1:0]   point_x_o;
  logic signed [OUT_W-1:0]   point_y_o;
  logic                      last_of_step_o;
  logic                      circle_done_o;

  int src_idle_pct = 23;
  int sink_idle_pct = 50;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int reg_writes = 0;

  class circle_scoreboard;
    typedef struct packed {
      logic signed [OUT_W-1:0] px;
      logic signed [OUT_W-1:0] py;
      logic                    last;
      logic                    done;
    } point_t;

    logic [COORD_W-1:0]      ctr_x;
    logic [COORD_W-1:0]      ctr_y;
    logic [RAD_W-1:0]        rad;
    logic signed [OCT_W-1:0] oct_x;
    logic signed [OCT_W-1:0] oct_y;
    logic signed [DEC_W-1:0] decision;
    bit                      finished;
    point_t                  point_q[$];
    int errors;
    int steps;
    int points;
    int circles;

    function new();
      ctr_x = CENTER_X_RST;
      ctr_y = CENTER_Y_RST;
      rad = RADIUS_RST;
      oct_x = '0;
      oct_y = '0;
      decision = '0;
      finished = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        CFG_CENTER_X: ctr_x = data;
        CFG_CENTER_Y: ctr_y = data;
        CFG_RADIUS:   rad = data[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_point(int k, int px, int py, bit done);
      point_t pt;
      pt.px = OUT_W'(px);
      pt.py = OUT_W'(py);
      pt.last = (k == 7);
      pt.done = done;
      point_q.push_back(pt);
    endfunction

    // One accepted step: load on restart, emit the eight mirrored points, advance.
    function void plot_step(bit restart);
      int x, y, nx, ny, cx, cy;
      bit done;
      if (restart) begin
        oct_x = '0;
        oct_y = OCT_W'(int'(rad));
        decision = DEC_W'(1 - int'(rad));
        finished = 1'b0;
      end
      if (finished) return;
      x = oct_x;
      y = oct_y;
      cx = ctr_x;
      cy = ctr_y;
      nx = x + 1;
      ny = y;
      if (decision < 0) begin
        decision = DEC_W'(decision + 2 * nx + 1);
      end else begin
        ny = y - 1;
        decision = DEC_W'(decision + 2 * (nx - ny) + 1);
      end
      oct_x = OCT_W'(nx);
      oct_y = OCT_W'(ny);
      done = nx > ny;
      finished = done;
      steps++;
      if (done) circles++;
      push_point(0, cx + x, cy + y, done);
      push_point(1, cx - x, cy + y, done);
      push_point(2, cx + x, cy - y, done);
      push_point(3, cx - x, cy - y, done);
      push_point(4, cx + y, cy + x, done);
      push_point(5, cx - y, cy + x, done);
      push_point(6, cx + y, cy - x, done);
      push_point(7, cx - y, cy - x, done);
    endfunction

    task flag_mismatch(string msg);
      if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task match_point(logic signed [OUT_W-1:0] px, logic signed [OUT_W-1:0] py,
                     logic last, logic done);
      point_t got;
      point_t exp_pt;
      got.px = px;
      got.py = py;
      got.last = last;
      got.done = done;
      points++;
      if (point_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected point (%0d,%0d) last=%b done=%b",
                                px, py, last, done));
        return;
      end
      exp_pt = point_q.pop_front();
      if (got !== exp_pt)
        flag_mismatch($sformatf("point (%0d,%0d) last=%b done=%b, want (%0d,%0d) last=%b done=%b",
                                px, py, last, done,
                                exp_pt.px, exp_pt.py, exp_pt.last, exp_pt.done));
    endtask
  endclass

  circle_scoreboard sb = new();

  midpoint_circle_rasterizer_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Pixel writer side: random stalls, or one long hold-off on request.
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.match_point(point_x_o, point_y_o, last_of_step_o, circle_done_o);
  end

  // Keeps valid high across back-to-back transactions; lowers it only for a gap.
  task automatic push_step(input bit rs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= rs;
    do @(posedge clk_i); while (in_stall_o);
    sb.plot_step(rs);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_config(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] rdata, input bit junk);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    if (junk) write_reg(CFG_UNUSED, COORD_W'($urandom));
    write_reg(CFG_RADIUS, rdata);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every expected point, then let any absorbed steps clear the pipe.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.point_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] pick_center();
    int p;
    p = $urandom_range(99);
    if (p < 15) return '0;
    if (p < 30) return '1;
    return COORD_W'($urandom_range(1023));
  endfunction

  task automatic random_config();
    int p;
    logic [RAD_W-1:0] r;
    p = $urandom_range(99);
    if (p < 10)      r = '0;
    else if (p < 60) r = RAD_W'($urandom_range(1, 20));
    else if (p < 85) r = RAD_W'($urandom_range(21, 120));
    else if (p < 95) r = RAD_W'($urandom_range(121, 510));
    else             r = '1;
    set_config(pick_center(), pick_center(), {1'($urandom_range(1)), r},
               $urandom_range(99) < 20);
  endtask

  task automatic run_segment(input int src_pct, input int sink_pct, input int quota,
                             input bit squeeze);
    int base;
    int phase_len;
    bit rs;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    base = sb.steps;
    while (sb.steps - base < quota) begin
      random_config();
      // most phases start a new circle; the rest keep drawing under the new center
      if ($urandom_range(99) < 80) push_step(1'b1);
      if (squeeze) begin
        long_hold_req = 1'b1;
        squeeze = 1'b0;
      end
      phase_len = $urandom_range(12, 40);
      for (int i = 0; i < phase_len && sb.steps - base < quota; i++) begin
        if (sb.finished) rs = ($urandom_range(99) < 75);
        else rs = ($urandom_range(99) < 5);
        push_step(rs);
      end
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: step with no circle, restart, restart mid-circle
    push_step(1'b0);
    push_step(1'b1);
    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b1);
    push_step(1'b0);
    drain();

    // zero radius at the origin, with a write to the unused index
    set_config('0, '0, '0, 1'b1);
    push_step(1'b1);
    push_step(1'b0);
    push_step(1'b1);
    drain();

    // largest radius at the far corner
    set_config('1, '1, 10'h1FF, 1'b0);
    push_step(1'b1);
    push_step(1'b0);
    push_step(1'b0);
    drain();

    // center moves while the circle is still active; radius write is not picked up
    set_config('0, '1, 10'h3FF, 1'b1);
    push_step(1'b0);
    push_step(1'b0);
    drain();

    // radius one with the top data bit set, then a full small circle
    set_config(10'd512, 10'd300, 10'h201, 1'b0);
    push_step(1'b1);
    push_step(1'b0);
    drain();
    set_config(10'd100, 10'd900, 10'h003, 1'b0);
    push_step(1'b1);
    while (!sb.finished) push_step(1'b0);
    drain();

    run_segment(23, 50, 90, 1'b0);
    run_segment(50, 23, 90, 1'b0);
    run_segment(0, 0, 90, 1'b1);

    $display("Checked %0d points from %0d drawing steps; %0d circles drawn to completion.",
             sb.points, sb.steps, sb.circles);
    $display("%0d register writes over full-scale centers and radii, one %0d-cycle hold-off.",
             reg_writes, LONG_HOLD);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d points outstanding.", sb.point_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
